[src/circular_buffer_deque_core_defines.svh]
// Assertion macros shared by the deque core RTL.
`ifndef CIRCULAR_BUFFER_DEQUE_CORE_DEFINES_SVH
`define CIRCULAR_BUFFER_DEQUE_CORE_DEFINES_SVH
`ifndef SYNTH
`define CBD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define CBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define CBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[src/cbd_pkg.sv]
// Types, constants and helpers for the deque core.
`default_nettype none
package cbd_pkg;
    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = IDX_W + 1;
    localparam int STEP_W     = $clog2(SUM_W);

    localparam int CFG_W      = 5;
    localparam int KIND_W     = 3;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int OUT_BITS   = DATA_W + STATUS_W + COUNT_W;
    localparam int M_TDATA_W  = 8 * ((OUT_BITS + 7) / 8);
    localparam int OUT_PAD_W  = M_TDATA_W - OUT_BITS;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_FRONT    = 3'd0,
        KIND_ADD_BACK     = 3'd1,
        KIND_REMOVE_FRONT = 3'd2,
        KIND_REMOVE_BACK  = 3'd3,
        KIND_READ_FRONT   = 3'd4,
        KIND_READ_BACK    = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_ACCESS,
        S_RESPOND
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } dp_sts_t;

    // Clamp the programmed capacity to 1..DEPTH.
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CFG_W-1:0] cfg);
        if (cfg == '0)
            return CNT_W'(1);
        else if (int'(cfg) > DEPTH)
            return CNT_W'(DEPTH);
        else
            return CNT_W'(cfg);
    endfunction
endpackage
`default_nettype wire

[src/cbd_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none
module cbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[addr] <= wdata;
            else
                rdata <= mem[addr];
        end
    end
endmodule
`default_nettype wire

[src/cbd_ctrl.sv]
// Request sequencer for the deque core.
`default_nettype none
`include "circular_buffer_deque_core_defines.svh"
module cbd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire cbd_pkg::dp_sts_t  sts,
    output cbd_pkg::ctrl_cmd_t     cmd
);
    import cbd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (sts.div_last)
                    state_next = S_ACCESS;
            end
            S_ACCESS:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESPOND;
            end
            S_RESPOND:
            begin
                // hold the result until the output register frees up
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    `CBD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready, "second request taken while busy")
    `CBD_ASSERT_NEXT(a_commit_then_respond, clk, rst_n, cmd.commit, state_reg == S_RESPOND, "commit not followed by respond")
endmodule
`default_nettype wire

[src/cbd_dp.sv]
// Deque datapath: pointers, slot remainder unit, element store, output register.
`default_nettype none
`include "circular_buffer_deque_core_defines.svh"
module cbd_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cbd_pkg::ctrl_cmd_t            cmd,
    output cbd_pkg::dp_sts_t                   sts,
    input  wire logic [cbd_pkg::KIND_W-1:0]    req_kind,
    input  wire logic [cbd_pkg::DATA_W-1:0]    req_value,
    input  wire logic                          cfg_valid,
    input  wire logic [cbd_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [cbd_pkg::M_TDATA_W-1:0]      m_tdata
);
    import cbd_pkg::*;

    logic [CFG_W-1:0]      cap_cfg_reg;
    logic [CNT_W-1:0]      cap_reg;
    logic [IDX_W-1:0]      front_reg;
    logic [IDX_W-1:0]      front_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    status_t               status_reg;
    status_t               status_next;
    logic                  rd_flag_reg;
    logic                  rd_flag_next;
    logic [IDX_W-1:0]      rem_reg;
    logic                  m_tvalid_reg;

    kind_t                 kind_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [SUM_W-1:0]      div_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [CNT_W-1:0]      cap_now;
    logic [CNT_W-1:0]      offset;
    logic [SUM_W-1:0]      trial;
    logic [SUM_W-1:0]      cap_ext;
    logic [IDX_W-1:0]      rem_step;
    logic                  full;
    logic                  empty;
    logic                  ram_en;
    logic                  ram_we;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic [DATA_W-1:0]     rd_value;

    assign cap_now = eff_cap(cap_cfg_reg);

    // distance from the front for the slot this request touches (for remove front, the new front)
    always_comb
    begin
        unique case (kind_t'(req_kind))
            KIND_ADD_FRONT:    offset = cap_now - CNT_W'(1);
            KIND_ADD_BACK:     offset = count_reg;
            KIND_REMOVE_FRONT: offset = CNT_W'(1);
            KIND_READ_BACK:    offset = count_reg - CNT_W'(1);
            default:           offset = '0;
        endcase
    end

    // restoring remainder, one dividend bit per step
    assign trial    = {rem_reg, div_reg[SUM_W-1]};
    assign cap_ext  = SUM_W'(cap_reg);
    assign rem_step = (trial >= cap_ext) ? IDX_W'(trial - cap_ext) : IDX_W'(trial);

    assign sts.div_last = (step_reg == STEP_W'(SUM_W - 1));
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign full  = (count_reg >= cap_reg);
    assign empty = (count_reg == '0);

    always_comb
    begin
        front_next   = front_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        rd_flag_next = rd_flag_reg;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        if (cmd.commit)
        begin
            status_next  = STAT_DONE;
            rd_flag_next = 1'b0;
            unique case (kind_reg)
                KIND_ADD_FRONT, KIND_ADD_BACK:
                begin
                    if (full)
                        status_next = STAT_FULL;
                    else
                    begin
                        ram_en     = 1'b1;
                        ram_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (kind_reg == KIND_ADD_FRONT)
                            front_next = rem_reg;
                    end
                end
                KIND_REMOVE_FRONT:
                begin
                    if (empty)
                        status_next = STAT_EMPTY;
                    else
                    begin
                        front_next = rem_reg;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                KIND_REMOVE_BACK:
                begin
                    if (empty)
                        status_next = STAT_EMPTY;
                    else
                        count_next = count_reg - CNT_W'(1);
                end
                KIND_READ_FRONT, KIND_READ_BACK:
                begin
                    if (empty)
                        status_next = STAT_EMPTY;
                    else
                    begin
                        ram_en       = 1'b1;
                        rd_flag_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    cbd_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (rem_reg),
        .wdata (value_reg),
        .rdata (ram_rdata)
    );

    assign rd_value = rd_flag_reg ? DATA_W'(ram_rdata) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg  <= CFG_W'(DEPTH);
            cap_reg      <= CNT_W'(DEPTH);
            front_reg    <= '0;
            count_reg    <= '0;
            status_reg   <= STAT_DONE;
            rd_flag_reg  <= 1'b0;
            rem_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                cap_cfg_reg <= cfg_data;
            if (cmd.load)
            begin
                cap_reg <= cap_now;
                rem_reg <= '0;
            end
            else if (cmd.step)
                rem_reg <= rem_step;
            front_reg   <= front_next;
            count_reg   <= count_next;
            status_reg  <= status_next;
            rd_flag_reg <= rd_flag_next;
            if (cmd.emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind_t'(req_kind);
            value_reg <= VALUE_BITS'(req_value);
            div_reg   <= SUM_W'(front_reg) + SUM_W'(offset);
            step_reg  <= '0;
        end
        else if (cmd.step)
        begin
            div_reg  <= div_reg << 1;
            step_reg <= step_reg + STEP_W'(1);
        end
        if (cmd.emit)
            m_tdata_reg <= {OUT_PAD_W'(0), COUNT_W'(count_reg), status_reg, rd_value};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `CBD_ASSERT_IMP(a_count_limit, clk, rst_n, 1'b1, int'(count_reg) <= DEPTH, "count above store depth")
    `CBD_ASSERT_IMP(a_rem_range, clk, rst_n, 1'b1, SUM_W'(rem_reg) < SUM_W'(cap_reg), "slot remainder not below capacity")
    `CBD_ASSERT_NEXT(a_add_count, clk, rst_n, cmd.commit && ram_we, count_reg == $past(count_reg) + CNT_W'(1), "accepted add did not bump count")
endmodule
`default_nettype wire

[src/circular_buffer_deque_core.sv]
// Top level of the fixed-capacity circular deque.
//
// Requests arrive on the s_ stream: s_tuser carries the request kind (add front,
// add back, remove front, remove back, read front, read back), s_tdata the value
// to add. Each request yields one result on the m_ stream with the read value,
// a status (done, empty, full) and the element count after the request.
// capacity_in_use is written on the cfg channel (always ready); the user must
// write it only while idle, as the block itself does not enforce this.
// One request is worked at a time. The slot index (front + offset) mod capacity
// comes from a restoring remainder unit that takes one dividend bit per cycle.
// A request passes the DIVIDE, ACCESS and RESPOND states, and the next request
// is taken only once the sequencer is back in IDLE.
// The finished result sits in an output register, so a new request is accepted
// while the previous result waits; if m_tready stays low the block holds the
// next result internally and stops taking requests until the register frees.
// Reset clears the count and front index and sets capacity_in_use to 16; the
// element store is not cleared.
`default_nettype none
module circular_buffer_deque_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [cbd_pkg::DATA_W-1:0]    s_tdata,   // [31:0] value
    input  wire logic [cbd_pkg::KIND_W-1:0]    s_tuser,   // [2:0] kind
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] read_value, [33:32] status, [38:34] count, [39] zero
    output logic [cbd_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cbd_pkg::CFG_W-1:0]     cfg_data
);
    import cbd_pkg::*;

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    assign cfg_ready = 1'b1;

    cbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cbd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_kind  (s_tuser),
        .req_value (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire
